// ----- design/occupancy_grid_ray_update_defines.svh -----
// assertion macros for the occupancy grid ray update block
`ifndef OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OGRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define OGRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ogru_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shared constants, types and helpers of the occupancy grid ray update block
package ogru_pkg;

  localparam int GRID_WIDTH  = 256;
  localparam int GRID_HEIGHT = 256;
  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W      = $clog2(CELL_COUNT);

  localparam int MM_PER_CELL = 50;
  localparam int RANGE_MM    = 50000;
  localparam int MM_W        = 16;
  localparam int MM_SUM_W    = MM_W + 1;
  localparam int MAX_CELL    = (RANGE_MM - 1 + MM_PER_CELL - 1) / MM_PER_CELL;
  localparam int COORD_W     = $clog2(MAX_CELL + 1);
  localparam int START_W     = 8;
  localparam int ERR_W       = COORD_W + 3;

  // ceil division by the cell size as a reciprocal multiply
  localparam int DIV_SHIFT   = 22;
  localparam int DIV_RECIP   = ((1 << DIV_SHIFT) + MM_PER_CELL - 1) / MM_PER_CELL;
  localparam int RECIP_W     = $clog2(DIV_RECIP + 1);
  localparam int PROD_W      = MM_SUM_W + RECIP_W;

  localparam int IDX_A       = $clog2(MAX_CELL * GRID_WIDTH + MAX_CELL + 1);
  localparam int IDX_B       = $clog2(CELL_COUNT + 1);
  localparam int IDX_W       = (IDX_A > IDX_B) ? IDX_A : IDX_B;
  localparam int RD_W        = (IDX_B > 16) ? IDX_B : 16;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 1'b1;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_BEAM  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic signed [7:0] VAL_UNKNOWN = -8'sd1;
  localparam logic signed [7:0] VAL_FREE    = 8'sd0;
  localparam logic signed [7:0] VAL_OCC     = 8'sd100;

  typedef enum logic [1:0] {
    CELL_UNKNOWN = 2'd0,
    CELL_FREE    = 2'd1,
    CELL_OCC     = 2'd2
  } cell_code_t;

  typedef enum logic [1:0] {
    GS_CLEAR,
    GS_IDLE,
    GS_TRACE,
    GS_READ
  } grid_state_t;

  typedef enum logic [2:0] {
    TR_IDLE,
    TR_DIV,
    TR_SETUP,
    TR_WALK,
    TR_OCC
  } trace_state_t;

  typedef struct packed {
    logic              go;
    logic [MM_W-1:0]   point_x_mm;
    logic [MM_W-1:0]   point_y_mm;
  } trace_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    cell_code_t        code;
  } mem_wr_t;

  function automatic logic [IDX_W-1:0] cell_index(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
    return IDX_W'(x) * IDX_W'(GRID_WIDTH) + IDX_W'(y);
  endfunction

  function automatic logic signed [7:0] cell_value_of(logic [1:0] code);
    logic signed [7:0] val;
    unique case (code)
      CELL_FREE: val = VAL_FREE;
      CELL_OCC:  val = VAL_OCC;
      default:   val = VAL_UNKNOWN;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ----- design/ogru_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// input and result channel interfaces
interface ogru_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] point_x_mm;
  logic [15:0] point_y_mm;
  logic [15:0] cell_address;

  modport source (output valid, kind, point_x_mm, point_y_mm, cell_address, input ready);
  modport sink   (input valid, kind, point_x_mm, point_y_mm, cell_address, output ready);
endinterface

interface ogru_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] cell_value;

  modport source (output valid, cell_value, input ready);
  modport sink   (input valid, cell_value, output ready);
endinterface
`default_nettype wire

// ----- design/ogru_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// generic single-write single-read ram with registered read data
module ogru_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- design/ogru_tracer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// beam endpoint conversion and bresenham line walker issuing cell writes
module ogru_tracer import ogru_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire trace_req_t         req,
  input  wire logic [START_W-1:0] start_x,
  input  wire logic [START_W-1:0] start_y,
  output      mem_wr_t            wr,
  output      logic               busy
);

  trace_state_t state_r, state_nxt;

  logic [MM_SUM_W-1:0]    mx_r, mx_nxt, my_r, my_nxt;
  logic [COORD_W-1:0]     ex_r, ex_nxt, ey_r, ey_nxt;
  logic [COORD_W-1:0]     u_r, u_nxt, bu_r, bu_nxt, v_r, v_nxt;
  logic [COORD_W-1:0]     dx_r, dx_nxt, dy_r, dy_nxt;
  logic                   steep_r, steep_nxt, up_r, up_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;

  logic                   in_range;
  logic [PROD_W-1:0]      prod_x, prod_y;
  logic [COORD_W-1:0]     sx, sy, adx, ady, a_u, a_v, b_u, b_v;
  logic [COORD_W-1:0]     u0, ue, v0, ve;
  logic                   steep0, swap0;
  logic [COORD_W-1:0]     px, py;
  logic signed [ERR_W-1:0] err_sum, dx_s, dy_s;
  logic                   step;
  logic [IDX_W-1:0]       walk_idx, occ_idx;

  // endpoint conversion
  assign in_range = (req.point_x_mm != '0) && (req.point_y_mm != '0) &&
                    (req.point_x_mm < MM_W'(RANGE_MM)) &&
                    (req.point_y_mm < MM_W'(RANGE_MM));
  assign prod_x = PROD_W'(mx_r) * PROD_W'(DIV_RECIP);
  assign prod_y = PROD_W'(my_r) * PROD_W'(DIV_RECIP);

  // line setup
  always_comb begin
    sx     = COORD_W'(start_x);
    sy     = COORD_W'(start_y);
    adx    = (ex_r >= sx) ? ex_r - sx : sx - ex_r;
    ady    = (ey_r >= sy) ? ey_r - sy : sy - ey_r;
    steep0 = ady > adx;
    a_u    = steep0 ? sy : sx;
    a_v    = steep0 ? sx : sy;
    b_u    = steep0 ? ey_r : ex_r;
    b_v    = steep0 ? ex_r : ey_r;
    swap0  = a_u > b_u;
    u0     = swap0 ? b_u : a_u;
    ue     = swap0 ? a_u : b_u;
    v0     = swap0 ? b_v : a_v;
    ve     = swap0 ? a_v : b_v;
  end

  // walk step
  always_comb begin
    px       = steep_r ? v_r : u_r;
    py       = steep_r ? u_r : v_r;
    dx_s     = ERR_W'($signed({1'b0, dx_r}));
    dy_s     = ERR_W'($signed({1'b0, dy_r}));
    err_sum  = err_r + dy_s;
    step     = (err_sum <<< 1) >= dx_s;
    walk_idx = cell_index(px, py);
    occ_idx  = cell_index(ex_r, ey_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      TR_IDLE:  if (req.go && in_range) state_nxt = TR_DIV;
      TR_DIV:   state_nxt = TR_SETUP;
      TR_SETUP: state_nxt = TR_WALK;
      TR_WALK:  if (u_r == bu_r) state_nxt = TR_OCC;
      TR_OCC:   state_nxt = TR_IDLE;
      default:  state_nxt = TR_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    ex_nxt    = ex_r;
    ey_nxt    = ey_r;
    u_nxt     = u_r;
    bu_nxt    = bu_r;
    v_nxt     = v_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    steep_nxt = steep_r;
    up_nxt    = up_r;
    err_nxt   = err_r;
    unique case (state_r)
      TR_IDLE: begin
        mx_nxt = MM_SUM_W'(req.point_x_mm) + MM_SUM_W'(MM_PER_CELL - 1);
        my_nxt = MM_SUM_W'(req.point_y_mm) + MM_SUM_W'(MM_PER_CELL - 1);
      end
      TR_DIV: begin
        ex_nxt = prod_x[DIV_SHIFT +: COORD_W];
        ey_nxt = prod_y[DIV_SHIFT +: COORD_W];
      end
      TR_SETUP: begin
        steep_nxt = steep0;
        u_nxt     = u0;
        bu_nxt    = ue;
        v_nxt     = v0;
        dx_nxt    = ue - u0;
        dy_nxt    = (v0 > ve) ? v0 - ve : ve - v0;
        up_nxt    = v0 < ve;
        err_nxt   = '0;
      end
      TR_WALK: begin
        u_nxt = u_r + COORD_W'(1);
        if (step) begin
          v_nxt   = up_r ? v_r + COORD_W'(1) : v_r - COORD_W'(1);
          err_nxt = err_sum - dx_s;
        end else begin
          err_nxt = err_sum;
        end
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = walk_idx[ADDR_W-1:0];
    wr.code = CELL_FREE;
    unique case (state_r)
      TR_WALK: begin
        wr.en = !((px == ex_r) && (py == ey_r)) && (walk_idx < IDX_W'(CELL_COUNT));
      end
      TR_OCC: begin
        wr.en   = occ_idx < IDX_W'(CELL_COUNT);
        wr.addr = occ_idx[ADDR_W-1:0];
        wr.code = CELL_OCC;
      end
      default: begin
      end
    endcase
    busy = state_r != TR_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    ex_r    <= ex_nxt;
    ey_r    <= ey_nxt;
    u_r     <= u_nxt;
    bu_r    <= bu_nxt;
    v_r     <= v_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    steep_r <= steep_nxt;
    up_r    <= up_nxt;
    err_r   <= err_nxt;
  end

endmodule
`default_nettype wire

// ----- design/occupancy_grid_ray_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// top level of the occupancy grid ray update block
//
//   channel  dir  payload                                          beat when
//   in_ch    in   kind, point_x_mm, point_y_mm, cell_address       valid && ready
//   out_ch   out  cell_value (signed)                              valid && ready
//   cfg      in   cfg_index, cfg_wdata (start_cell_x, start_cell_y) cfg_we
//
// a beam issues at most one cell write per cycle through the single ram write port
// a clear item and reset both run a sweep over all GRID_WIDTH * GRID_HEIGHT cells (65536)
// a read's result sits in an output register, so the next item is
// taken while the result waits, but a further read holds until the register is free
`include "occupancy_grid_ray_update_defines.svh"
module occupancy_grid_ray_update import ogru_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ogru_in_if.sink                    in_ch,
  ogru_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  grid_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [START_W-1:0]    start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [7:0]     out_value_r, out_value_nxt;
  logic                  rd_ok_r, rd_ok_nxt;

  logic                  accept, rd_en, load_out;
  logic [1:0]            rd_data;
  trace_req_t            tr_req;
  mem_wr_t               tr_wr, mem_wr;
  logic                  tr_busy;

  assign accept   = in_ch.valid && in_ch.ready;
  assign rd_en    = accept && (in_ch.kind == KIND_READ);
  assign load_out = (state_r == GS_READ) && (!out_valid_r || out_ch.ready);

  assign tr_req.go         = accept && (in_ch.kind == KIND_BEAM);
  assign tr_req.point_x_mm = in_ch.point_x_mm;
  assign tr_req.point_y_mm = in_ch.point_y_mm;

  ogru_tracer u_tracer (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tr_req),
    .start_x (start_x_r),
    .start_y (start_y_r),
    .wr      (tr_wr),
    .busy    (tr_busy)
  );

  ogru_ram #(
    .WIDTH (2),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk     (clk),
    .wr_en   (mem_wr.en),
    .wr_addr (mem_wr.addr),
    .wr_data (mem_wr.code),
    .rd_en   (rd_en),
    .rd_addr (ADDR_W'(in_ch.cell_address)),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      GS_CLEAR: if (clr_cnt_r == ADDR_W'(CELL_COUNT - 1)) state_nxt = GS_IDLE;
      GS_IDLE: begin
        if (accept) begin
          unique case (in_ch.kind)
            KIND_CLEAR: state_nxt = GS_CLEAR;
            KIND_BEAM:  state_nxt = GS_TRACE;
            KIND_READ:  state_nxt = GS_READ;
            default:    state_nxt = GS_IDLE;
          endcase
        end
      end
      GS_TRACE: if (!tr_busy) state_nxt = GS_IDLE;
      GS_READ:  if (load_out) state_nxt = GS_IDLE;
      default:  state_nxt = GS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = state_r == GS_IDLE;
    mem_wr      = tr_wr;
    if (state_r == GS_CLEAR) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = clr_cnt_r;
      mem_wr.code = CELL_UNKNOWN;
    end
    out_ch.valid      = out_valid_r;
    out_ch.cell_value = out_value_r;
  end

  // register next values
  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    rd_ok_nxt     = rd_ok_r;
    if (state_r == GS_CLEAR) begin
      clr_cnt_nxt = (clr_cnt_r == ADDR_W'(CELL_COUNT - 1)) ? '0 : clr_cnt_r + ADDR_W'(1);
    end
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_X: start_x_nxt = START_W'(cfg_wdata);
        CFG_START_Y: start_y_nxt = START_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
    if (rd_en) begin
      rd_ok_nxt = RD_W'(in_ch.cell_address) < RD_W'(CELL_COUNT);
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = rd_ok_r ? cell_value_of(rd_data) : VAL_UNKNOWN;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= GS_CLEAR;
      clr_cnt_r   <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    rd_ok_r     <= rd_ok_nxt;
  end

  `OGRU_ASSERT_NOW(a_no_take_while_tracing, tr_busy, !in_ch.ready, "item taken during beam walk")
  `OGRU_ASSERT_NOW(a_sweep_writes_unknown, state_r == GS_CLEAR,
                   mem_wr.en && (mem_wr.code == CELL_UNKNOWN), "clear sweep write missing")
  `OGRU_ASSERT_NEXT(a_read_lands, load_out, out_valid_r, "read result not presented")
  `OGRU_ASSERT_NOW(a_tracer_quiet, state_r != GS_TRACE, !tr_busy, "tracer busy outside trace")

endmodule
`default_nettype wire

// ----- dv/tb_occupancy_grid_ray_update.sv -----
`timescale 1ns / 1ps
// self-checking testbench: directed and random beats checked against a grid model
module tb_occupancy_grid_ray_update;
  import ogru_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES    = 1100;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PRINT_CAP        = 30;
  localparam int NEAR_SPAN        = 60;
  localparam int PHASE_ITEMS      = 105;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] point_x_mm;
    logic [15:0] point_y_mm;
    logic [15:0] cell_address;
  } grid_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ogru_in_if  in_ch();
  ogru_out_if out_ch();

  occupancy_grid_ray_update dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  grid_item_t        pending_items[$];
  logic signed [7:0] expected_values[$];
  cell_code_t        grid_model [CELL_COUNT];
  grid_item_t        offered_item;
  logic signed [7:0] wanted_value;

  int model_start_x, model_start_y;
  int last_end_x, last_end_y;
  int tx_idle_pct, rx_idle_pct;
  int hold_requests, holds_served, hold_left;
  int error_count, results_checked, beams_taken, reads_taken, clears_taken;

  always #2 clk = ~clk;

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // grid model

  function automatic int span(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void expect_value(logic signed [7:0] val);
    expected_values.insert(expected_values.size(), val);
  endfunction

  function automatic void set_model_cell(int x, int y, cell_code_t code);
    int idx;
    if (x >= 0 && y >= 0) begin
      idx = x * GRID_WIDTH + y;
      if (idx < CELL_COUNT) grid_model[idx] = code;
    end
  endfunction

  function automatic void mark_ray(int ex, int ey);
    int ax, ay, bx, by, t, dx, dy, err, ystep, u, v, px, py;
    bit steep;
    ax = model_start_x;
    ay = model_start_y;
    bx = ex;
    by = ey;
    steep = span(by, ay) > span(bx, ax);
    if (steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx = bx - ax;
    dy = span(by, ay);
    err = 0;
    ystep = (ay < by) ? 1 : -1;
    v = ay;
    for (u = ax; u <= bx; u++) begin
      px = steep ? v : u;
      py = steep ? u : v;
      err += dy;
      if (2 * err >= dx) begin
        v += ystep;
        err -= dx;
      end
      if (px != ex || py != ey) set_model_cell(px, py, CELL_FREE);
    end
    set_model_cell(ex, ey, CELL_OCC);
  endfunction

  function automatic void update_grid_model(grid_item_t it);
    int mx, my;
    cell_code_t code;
    mx = it.point_x_mm;
    my = it.point_y_mm;
    case (it.kind)
      KIND_CLEAR: begin
        foreach (grid_model[i]) grid_model[i] = CELL_UNKNOWN;
        clears_taken++;
      end
      KIND_BEAM: begin
        beams_taken++;
        if (mx > 0 && my > 0 && mx < RANGE_MM && my < RANGE_MM)
          mark_ray((mx + MM_PER_CELL - 1) / MM_PER_CELL, (my + MM_PER_CELL - 1) / MM_PER_CELL);
      end
      KIND_READ: begin
        reads_taken++;
        code = (int'(it.cell_address) < CELL_COUNT) ? grid_model[it.cell_address] : CELL_UNKNOWN;
        case (code)
          CELL_FREE: expect_value(VAL_FREE);
          CELL_OCC:  expect_value(VAL_OCC);
          default:   expect_value(VAL_UNKNOWN);
        endcase
      end
      default: ;
    endcase
  endfunction

  // driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) update_grid_model(offered_item);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered_item = pending_items.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.kind         <= offered_item.kind;
          in_ch.point_x_mm   <= offered_item.point_x_mm;
          in_ch.point_y_mm   <= offered_item.point_y_mm;
          in_ch.cell_address <= offered_item.cell_address;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("cell_value %0d with no read outstanding",
                                    out_ch.cell_value));
        end else begin
          wanted_value = expected_values.pop_front();
          if (out_ch.cell_value !== wanted_value)
            report_mismatch($sformatf("cell_value %0d, expected %0d",
                                      out_ch.cell_value, wanted_value));
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left <= LONG_HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // stimulus

  function automatic int clamp_cell(int c);
    return (c < 1) ? 1 : ((c > MAX_CELL) ? MAX_CELL : c);
  endfunction

  function automatic int mm_for_cell(int c);
    int lo;
    lo = (c >= MAX_CELL) ? 1 : 0;
    return MM_PER_CELL * c - int'($urandom_range(49, lo));
  endfunction

  function automatic void queue_item(logic [1:0] kind, int px, int py, int addr);
    grid_item_t it;
    it.kind         = kind;
    it.point_x_mm   = 16'(px);
    it.point_y_mm   = 16'(py);
    it.cell_address = 16'(addr);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void queue_beam_to_cell(int cx, int cy);
    last_end_x = cx;
    last_end_y = cy;
    queue_item(KIND_BEAM, mm_for_cell(cx), mm_for_cell(cy), $urandom);
  endfunction

  // read a cell on or next to the last traced line
  function automatic void queue_read_near_line();
    int t, jx, jy, x, y;
    t  = $urandom_range(100);
    jx = $urandom_range(2);
    jy = $urandom_range(2);
    x = model_start_x + (last_end_x - model_start_x) * t / 100 + jx - 1;
    y = model_start_y + (last_end_y - model_start_y) * t / 100 + jy - 1;
    if (x < 0) x = 0;
    if (y < 0) y = 0;
    queue_item(KIND_READ, $urandom, $urandom, x * GRID_WIDTH + y);
  endfunction

  function automatic void queue_random_items(int count);
    int r, s, cx, cy, px, py;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 3) begin
        queue_item(KIND_UNUSED, $urandom, $urandom, $urandom);
      end else if (r < 48) begin
        s = $urandom_range(9);
        if (s < 7) begin
          cx = $urandom_range(2 * NEAR_SPAN);
          cy = $urandom_range(2 * NEAR_SPAN);
          queue_beam_to_cell(clamp_cell(model_start_x + cx - NEAR_SPAN),
                             clamp_cell(model_start_y + cy - NEAR_SPAN));
        end else if (s == 7) begin
          queue_beam_to_cell($urandom_range(MAX_CELL, 1), $urandom_range(MAX_CELL, 1));
        end else begin
          px = $urandom_range(65535);
          py = $urandom_range(65535);
          if ($urandom_range(3) == 0) px = $urandom_range(1) ? 0 : $urandom_range(65535, RANGE_MM);
          if ($urandom_range(3) == 0) py = $urandom_range(1) ? 0 : $urandom_range(65535, RANGE_MM);
          queue_item(KIND_BEAM, px, py, $urandom);
        end
      end else if ($urandom_range(3) != 0) begin
        queue_read_near_line();
      end else begin
        queue_item(KIND_READ, $urandom, $urandom, $urandom_range(65535));
      end
    end
  endfunction

  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_values.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_start_cell(int x, int y);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_X;
    cfg_wdata <= 8'(x);
    @(posedge clk);
    model_start_x = x;
    cfg_index <= CFG_START_Y;
    cfg_wdata <= 8'(y);
    @(posedge clk);
    model_start_y = y;
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int sx, int sy, int tx_pct, int rx_pct, bit with_clear,
                           bit with_hold, int count);
    int n;
    set_start_cell(sx, sy);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (with_clear) queue_item(KIND_CLEAR, $urandom, $urandom, $urandom);
    queue_beam_to_cell(clamp_cell(sx), clamp_cell(sy));
    queue_item(KIND_READ, $urandom, $urandom, clamp_cell(sx) * GRID_WIDTH + clamp_cell(sy));
    if (with_hold) begin
      // back-to-back reads against a stalled result channel
      hold_requests++;
      for (n = 0; n < 12; n++) queue_read_near_line();
    end
    queue_random_items(count);
    queue_read_near_line();
    wait_until_drained();
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_START_X;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_CLEAR;
    in_ch.point_x_mm   = '0;
    in_ch.point_y_mm   = '0;
    in_ch.cell_address = '0;
    out_ch.ready       = 1'b0;
    foreach (grid_model[i]) grid_model[i] = CELL_UNKNOWN;
    model_start_x = 0;
    model_start_y = 0;
    last_end_x    = 1;
    last_end_y    = 1;
    tx_idle_pct   = 7;
    rx_idle_pct   = 71;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ignored points at both ends of the range
    queue_item(KIND_READ, 0, 0, 0);
    queue_item(KIND_BEAM, 0, 1000, 0);
    queue_item(KIND_BEAM, 1000, 0, 65535);
    queue_item(KIND_BEAM, RANGE_MM, 1000, 0);
    queue_item(KIND_BEAM, 1000, 65535, 0);
    queue_item(KIND_READ, 0, 0, 20 * GRID_WIDTH + 20);
    // smallest and largest endpoints
    queue_item(KIND_BEAM, 1, 1, 0);
    queue_item(KIND_READ, 0, 0, 0);
    queue_item(KIND_READ, 0, 0, GRID_WIDTH + 1);
    queue_item(KIND_BEAM, RANGE_MM - 1, RANGE_MM - 1, 0);
    queue_item(KIND_READ, 0, 0, 2 * GRID_WIDTH + 2);
    queue_item(KIND_READ, 65535, 65535, CELL_COUNT - 1);
    // shallow line leaving the grid, steep line with rows wrapping
    queue_item(KIND_BEAM, 49950, 50, 0);
    queue_item(KIND_READ, 0, 0, 100 * GRID_WIDTH);
    queue_item(KIND_BEAM, 51, 49951, 0);
    queue_item(KIND_READ, 0, 0, 300);
    queue_item(KIND_READ, 0, 0, GRID_WIDTH + 44);
    queue_item(KIND_UNUSED, 65535, 65535, 65535);
    queue_item(KIND_CLEAR, 65535, 65535, 65535);
    queue_item(KIND_READ, 0, 0, GRID_WIDTH + 1);
    queue_item(KIND_BEAM, 50, 50, 0);
    queue_item(KIND_READ, 0, 0, GRID_WIDTH + 1);
    wait_until_drained();

    run_phase(255, 255, 7, 71, 1'b1, 1'b0, PHASE_ITEMS);
    run_phase(0, 255, 71, 7, 1'b0, 1'b0, PHASE_ITEMS);
    run_phase(255, 0, 71, 7, 1'b0, 1'b0, PHASE_ITEMS);
    run_phase($urandom_range(255, 1), $urandom_range(255, 1), 0, 0, 1'b0, 1'b1, PHASE_ITEMS);
    run_phase($urandom_range(255, 1), $urandom_range(255, 1), 0, 0, 1'b1, 1'b0, PHASE_ITEMS);

    $display("covered %0d beams, %0d reads and %0d clears; %0d cell values checked",
             beams_taken, reads_taken, clears_taken, results_checked);
    $display("start cells at the corners of the 8-bit range and two random positions");
    if (error_count == 0) begin
      $display("[occupancy_grid_ray_update] OK");
    end else begin
      $display("[occupancy_grid_ray_update] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timed out with %0d beats queued and %0d reads outstanding",
             pending_items.size(), expected_values.size());
    $display("[occupancy_grid_ray_update] ERROR");
    $finish;
  end

endmodule
